@@ hw/rtl/tkct_pkg.sv @@
// Shared types and constants for the top-k count tracker.
package tkct_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int CAP_W    = 5;
    localparam int COUNT_W  = 32;
    localparam int TAG_W    = 32;
    localparam int TOTAL_W  = 32;
    localparam int KIND_W   = 2;
    localparam int CFG_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic             EMIT_RESET = 1'b1;

    // opcodes on s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_EMIT     = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PASS    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_EVICT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [COUNT_W-1:0]   new_count;
        logic [TAG_W-1:0]     new_tag;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/tkct_cell.sv @@
// One slot of the sorted chain: holds a count and tag, shifts with its neighbors.
module tkct_cell
    import tkct_pkg::*;
(
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic               self_valid,
    input  logic [COUNT_W-1:0] left_count,
    input  logic [TAG_W-1:0]   left_tag,
    input  logic               left_le,
    input  logic [COUNT_W-1:0] right_count,
    input  logic [TAG_W-1:0]   right_tag,
    input  logic               right_le,
    output logic [COUNT_W-1:0] count,
    output logic [TAG_W-1:0]   tag,
    output logic               le
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;

    assign le    = self_valid && (count_reg <= ctrl.new_count);
    assign count = count_reg;
    assign tag   = tag_reg;

    always_comb begin
        count_next = count_reg;
        tag_next   = tag_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (!le) begin
                    if (left_le) begin
                        count_next = ctrl.new_count;
                        tag_next   = ctrl.new_tag;
                    end else begin
                        count_next = left_count;
                        tag_next   = left_tag;
                    end
                end
            end
            CELL_EVICT: begin
                if (right_le) begin
                    count_next = right_count;
                    tag_next   = right_tag;
                end else if (le) begin
                    count_next = ctrl.new_count;
                    tag_next   = ctrl.new_tag;
                end
            end
            CELL_ROTATE: begin
                count_next = left_count;
                tag_next   = left_tag;
            end
            default: begin
                count_next = count_reg;
                tag_next   = tag_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        tag_reg   <= tag_next;
    end

endmodule

@@ hw/rtl/top_k_count_tracker.sv @@
// Top-k count tracker: sorted chain of cells, pass-through counter and dump sequencer.
// Insert: a pass-through result appears in the output register next cycle.
// Dump: the chain rotates one full lap (MAX_ENTRIES steps, one per free output slot),
//   entries leave from the top cell, then the summary.
// Reset: occupancy and pass counter cleared, capacity 16, emitting on; cell contents kept.
module top_k_count_tracker
    import tkct_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // occurrences[31:0], item_tag[63:32]
    input  logic         s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_count[31:0], out_tag[63:32], total[95:64]
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [TOTAL_W-1:0] passed_reg, passed_next;
    logic [CAP_W-1:0]   capacity_reg;
    logic               emit_reg;

    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [COUNT_W-1:0] ocount_reg, ocount_next;
    logic [TAG_W-1:0]   otag_reg, otag_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               last_reg, last_next;

    logic [COUNT_W-1:0] cell_count [MAX_ENTRIES];
    logic [TAG_W-1:0]   cell_tag   [MAX_ENTRIES];
    logic               cell_le    [MAX_ENTRIES];
    cell_ctrl_t         ctrl;

    logic [COUNT_W-1:0] in_count;
    logic [TAG_W-1:0]   in_tag;
    logic [CMP_W-1:0]   cap_ext, eff_cap;
    logic               cap_zero, full, lt0, out_free, in_fire, is_insert;
    logic               pass_emit, step_emit;

    assign in_count  = s_tdata[31:0];
    assign in_tag    = s_tdata[63:32];
    assign is_insert = (s_tuser == OP_INSERT);

    assign cap_ext  = CMP_W'(capacity_reg);
    assign eff_cap  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
    assign cap_zero = (eff_cap == '0);
    assign full     = (CMP_W'(occ_reg) >= eff_cap);
    assign lt0      = (cell_count[0] < in_count);
    assign out_free = !m_valid_reg || m_tready;

    assign pass_emit = is_insert && cap_zero && emit_reg;
    assign s_tready  = (state_reg == ST_IDLE) && (out_free || !pass_emit);
    assign in_fire   = s_tvalid && s_tready;

    // entry at the top cell is a stored one once MAX - occ rotations have passed
    assign step_emit = emit_reg &&
        (({1'b0, step_reg} + {1'b0, occ_reg}) >= (CNT_W + 1)'(MAX_ENTRIES));

    assign cfg_ready = 1'b1;

    always_comb begin
        ctrl.op        = CELL_HOLD;
        ctrl.new_count = in_count;
        ctrl.new_tag   = in_tag;
        if (state_reg == ST_IDLE) begin
            if (in_fire && is_insert && !cap_zero) begin
                if (!full) begin
                    ctrl.op = CELL_INSERT;
                end else if (lt0) begin
                    ctrl.op = CELL_EVICT;
                end
            end
        end else if (out_free && (step_reg != CNT_W'(MAX_ENTRIES))) begin
            ctrl.op = CELL_ROTATE;
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [COUNT_W-1:0] l_count, r_count;
        logic [TAG_W-1:0]   l_tag, r_tag;
        logic               l_le, r_le;

        if (i == 0) begin : g_first
            assign l_count = cell_count[MAX_ENTRIES-1];
            assign l_tag   = cell_tag[MAX_ENTRIES-1];
            assign l_le    = 1'b1;
        end else begin : g_mid_l
            assign l_count = cell_count[i-1];
            assign l_tag   = cell_tag[i-1];
            assign l_le    = cell_le[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_last
            assign r_count = in_count;
            assign r_tag   = in_tag;
            assign r_le    = 1'b0;
        end else begin : g_mid_r
            assign r_count = cell_count[i+1];
            assign r_tag   = cell_tag[i+1];
            assign r_le    = cell_le[i+1];
        end

        tkct_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .self_valid  (CNT_W'(i) < occ_reg),
            .left_count  (l_count),
            .left_tag    (l_tag),
            .left_le     (l_le),
            .right_count (r_count),
            .right_tag   (r_tag),
            .right_le    (r_le),
            .count       (cell_count[i]),
            .tag         (cell_tag[i]),
            .le          (cell_le[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        occ_next     = occ_reg;
        passed_next  = passed_reg;
        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        ocount_next  = ocount_reg;
        otag_next    = otag_reg;
        total_next   = total_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!is_insert) begin
                        state_next = ST_DUMP;
                        step_next  = '0;
                    end else if (cap_zero) begin
                        passed_next = passed_reg + 1'b1;
                        if (emit_reg) begin
                            m_valid_next = 1'b1;
                            kind_next    = KIND_PASS;
                            ocount_next  = in_count;
                            otag_next    = in_tag;
                            total_next   = '0;
                            last_next    = 1'b1;
                        end
                    end else if (!full) begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    if (step_reg == CNT_W'(MAX_ENTRIES)) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_SUMMARY;
                        ocount_next  = '0;
                        otag_next    = '0;
                        total_next   = cap_zero ? passed_reg : TOTAL_W'(occ_reg);
                        last_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                        if (step_emit) begin
                            m_valid_next = 1'b1;
                            kind_next    = KIND_STORED;
                            ocount_next  = cell_count[MAX_ENTRIES-1];
                            otag_next    = cell_tag[MAX_ENTRIES-1];
                            total_next   = '0;
                            last_next    = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            occ_reg      <= '0;
            passed_reg   <= '0;
            m_valid_reg  <= 1'b0;
            capacity_reg <= CAP_RESET;
            emit_reg     <= EMIT_RESET;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            occ_reg     <= occ_next;
            passed_reg  <= passed_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                    CFG_EMIT:     emit_reg     <= cfg_data[0];
                    default:      emit_reg     <= emit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        ocount_reg <= ocount_next;
        otag_reg   <= otag_next;
        total_reg  <= total_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {total_reg, otag_reg, ocount_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

@@ tb/sv/tkct_checker.sv @@
// Scoreboard for the top-k count tracker: tracks the sorted store and checks every result item.
module tkct_checker
    import tkct_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [95:0]       m_tdata,
    input  logic [1:0]        m_tuser,
    input  logic              m_tlast,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                mismatches,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [TAG_W-1:0]   tag;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } result_t;

    result_t            want_q[$];
    logic [COUNT_W-1:0] cnt_tbl[MAX_ENTRIES];
    logic [TAG_W-1:0]   tag_tbl[MAX_ENTRIES];
    int unsigned        occ;
    logic [TOTAL_W-1:0] passed;
    logic [CAP_W-1:0]   cap_reg;
    logic               emit_reg;
    string              field_name[5] = '{"kind", "count", "tag", "total", "last"};

    function automatic void push_result(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] count,
                                        logic [TAG_W-1:0] tag, logic [TOTAL_W-1:0] total,
                                        logic last);
        result_t r;
        r.kind  = kind;
        r.count = count;
        r.tag   = tag;
        r.total = total;
        r.last  = last;
        want_q.push_back(r);
    endfunction

    function automatic void track_item(logic op, logic [COUNT_W-1:0] cnt, logic [TAG_W-1:0] tag);
        int unsigned lim;
        int unsigned pos;
        lim = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
        if (op == OP_INSERT) begin
            if (lim == 0) begin
                passed = passed + 1;
                if (emit_reg)
                    push_result(KIND_PASS, cnt, tag, '0, 1'b1);
                return;
            end
            // full store: beat the oldest smallest entry or drop
            if (occ >= lim && occ > 0) begin
                if (cnt_tbl[0] >= cnt)
                    return;
                for (int i = 1; i < occ; i++) begin
                    cnt_tbl[i-1] = cnt_tbl[i];
                    tag_tbl[i-1] = tag_tbl[i];
                end
                occ--;
            end
            pos = 0;
            while (pos < occ && cnt_tbl[pos] <= cnt)
                pos++;
            for (int i = occ; i > pos; i--) begin
                cnt_tbl[i] = cnt_tbl[i-1];
                tag_tbl[i] = tag_tbl[i-1];
            end
            if (pos < MAX_ENTRIES) begin
                cnt_tbl[pos] = cnt;
                tag_tbl[pos] = tag;
                occ++;
            end
        end else begin
            if (emit_reg)
                for (int i = occ; i > 0; i--)
                    push_result(KIND_STORED, cnt_tbl[i-1], tag_tbl[i-1], '0, 1'b0);
            push_result(KIND_SUMMARY, '0, '0, (lim > 0) ? TOTAL_W'(occ) : passed, 1'b1);
        end
    endfunction

    always @(posedge aclk) begin
        result_t     want;
        logic [31:0] ef[5];
        logic [31:0] af[5];
        if (!aresetn) begin
            occ        = 0;
            passed     = '0;
            cap_reg    = CAP_RESET;
            emit_reg   = EMIT_RESET;
            mismatches = 0;
            want_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected item kind=%0d count=%h tag=%h total=%h last=%b",
                             $time, m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                             m_tlast);
                    mismatches++;
                end else begin
                    want  = want_q.pop_front();
                    ef[0] = 32'(want.kind);
                    ef[1] = want.count;
                    ef[2] = want.tag;
                    ef[3] = want.total;
                    ef[4] = 32'(want.last);
                    af[0] = 32'(m_tuser);
                    af[1] = m_tdata[31:0];
                    af[2] = m_tdata[63:32];
                    af[3] = m_tdata[95:64];
                    af[4] = 32'(m_tlast);
                    for (int f = 0; f < 5; f++)
                        if (af[f] !== ef[f]) begin
                            $display("%0t: %s mismatch, expected %h, got %h",
                                     $time, field_name[f], ef[f], af[f]);
                            mismatches++;
                        end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CAPACITY)
                    cap_reg = cfg_data[CAP_W-1:0];
                else
                    emit_reg = cfg_data[0];
            end
            if (s_tvalid && s_tready)
                track_item(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
        pending = want_q.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the top-k count tracker bench: clock, reset, item and register traffic, verdict.
module testbench
    import tkct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = MAX_ENTRIES_DEF + 8;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;
    logic              s_tuser = OP_INSERT;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_CAPACITY;
    logic [CFG_W-1:0]  cfg_data = '0;
    int                mismatches;
    int                pending;
    bit                steady = 1'b0;
    int                stall_left = 0;

    always #5 aclk = ~aclk;

    top_k_count_tracker dut (.*);

    tkct_checker checker_i (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 20);
            6, 7:             return $urandom;
            8:                return 32'h0;
            default:          return 32'hFFFF_FFFF;
        endcase
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (steady || $urandom_range(0, 3) != 0) begin
            m_tready = 1'b1;
        end else begin
            stall_left = pick_gap();
            m_tready   = 1'b0;
        end
    end

    task automatic send_item(logic op, logic [31:0] cnt, logic [31:0] tag);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {tag, cnt};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // drain all expected items, then let a dump or insert in flight finish
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        #6ms;
        $display("** top_k_count_tracker: FAILED **");
        $finish;
    end

    initial begin
        int sent;
        int phase;
        int n;
        logic [CFG_W-1:0] cap;
        logic emit;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty dump, count extremes, ties, shrink, pass-through, muted
        send_item(OP_DUMP, $urandom, $urandom);
        send_item(OP_INSERT, 32'h0, 32'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'd5, 32'h0000_00A1);
        send_item(OP_INSERT, 32'd5, 32'h0000_00A2);
        send_item(OP_INSERT, 32'd5, 32'h0000_00A3);
        send_item(OP_INSERT, 32'd7, 32'h1234_5678);
        send_item(OP_DUMP, 32'h0, 32'h0);
        settle();
        write_reg(CFG_CAPACITY, 5'd3);
        send_item(OP_INSERT, 32'd0, 32'hDEAD_0001);
        send_item(OP_INSERT, 32'd1, 32'hDEAD_0002);
        send_item(OP_INSERT, 32'd5, 32'h0000_00A4);
        send_item(OP_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();
        write_reg(CFG_CAPACITY, 5'd0);
        send_item(OP_INSERT, 32'd9, 32'h0000_00B1);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_DUMP, 32'h0, 32'h0);
        settle();
        write_reg(CFG_EMIT, 5'd0);
        send_item(OP_INSERT, 32'd3, 32'h5555_AAAA);
        send_item(OP_DUMP, 32'h0, 32'h0);
        settle();
        write_reg(CFG_CAPACITY, 5'd31);
        write_reg(CFG_EMIT, 5'd1);
        send_item(OP_INSERT, 32'd6, 32'hAAAA_5555);
        send_item(OP_DUMP, 32'h0, 32'h0);
        settle();
        write_reg(CFG_CAPACITY, 5'd1);
        send_item(OP_INSERT, 32'd8, 32'h0F0F_F0F0);
        send_item(OP_DUMP, 32'h0, 32'h0);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < 150) begin
            case (phase % 6)
                0:       cap = 5'd16;
                1:       cap = 5'd31;
                2:       cap = 5'd0;
                3:       cap = 5'd1;
                4:       cap = CFG_W'($urandom_range(2, 15));
                default: cap = CFG_W'($urandom_range(0, 31));
            endcase
            emit = ($urandom_range(0, 3) != 0);
            write_reg(CFG_CAPACITY, cap);
            write_reg(CFG_EMIT, {{(CFG_W-1){1'b0}}, emit});
            steady = (phase % 4 == 1);
            n = $urandom_range(12, 24);
            for (int k = 0; k < n; k++) begin
                if (k == n - 1 || $urandom_range(0, 7) == 0)
                    send_item(OP_DUMP, $urandom, $urandom);
                else
                    send_item(OP_INSERT, pick_count(), $urandom);
                sent++;
            end
            settle();
            steady = 1'b0;
            phase++;
        end

        if (mismatches == 0 && pending == 0) begin
            $display("** top_k_count_tracker: PASSED **");
        end else begin
            $display("** top_k_count_tracker: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tkct_pkg.sv
hw/rtl/tkct_cell.sv
hw/rtl/top_k_count_tracker.sv
tb/sv/tkct_checker.sv
tb/sv/testbench.sv
